/* rtl/dbsf_pkg.sv */
// ----------------------------------------------------------------------------
// dbsf_pkg
// Shared types and constants for the double-buffered shape fill engine.
// ----------------------------------------------------------------------------
package dbsf_pkg;

   localparam int DBSF_MAP_WIDTH  = 64;
   localparam int DBSF_MAP_HEIGHT = 64;

   // request command codes
   typedef enum logic [2:0] {
      CMD_CLEAR = 3'd0,
      CMD_DISC  = 3'd1,
      CMD_BOX   = 3'd2,
      CMD_SWAP  = 3'd3,
      CMD_READ  = 3'd4
   } dbsf_cmd_type;

   // sequencer states of the top level
   typedef enum logic [2:0] {
      ST_INIT,    // clearing pass over both pages after reset
      ST_IDLE,
      ST_SETUP,   // disc unit squares its operands
      ST_SCAN,    // one pixel of the back page per cycle
      ST_RADDR,
      ST_RMEM,
      ST_DONE
   } dbsf_state_type;

   // sequencer -> disc unit
   typedef struct packed {
      logic start;
      logic col_step;
      logic row_step;
   } dbsf_disc_ctl_type;

   // disc unit -> sequencer
   typedef struct packed {
      logic busy;
      logic in_disc;
   } dbsf_disc_sts_type;

endpackage

/* rtl/dbsf_req_if.sv */
// ----------------------------------------------------------------------------
// dbsf_req_if
// Request channel: valid/ready handshake with command payload.
// ----------------------------------------------------------------------------
interface dbsf_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        cmd;
   logic signed [9:0] x_a;
   logic signed [9:0] y_a;
   logic signed [9:0] x_b;
   logic signed [9:0] y_b;
   logic [9:0]        radius;
   logic [7:0]        color;

   modport source (output valid, cmd, x_a, y_a, x_b, y_b, radius, color, input ready);
   modport sink   (input valid, cmd, x_a, y_a, x_b, y_b, radius, color, output ready);
endinterface

/* rtl/dbsf_rsp_if.sv */
// ----------------------------------------------------------------------------
// dbsf_rsp_if
// Response channel: valid/ready handshake with one pixel value.
// ----------------------------------------------------------------------------
interface dbsf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_value;

   modport source (output valid, pixel_value, input ready);
   modport sink   (input valid, pixel_value, output ready);
endinterface

/* rtl/dbsf_disc_unit.sv */
// ----------------------------------------------------------------------------
// dbsf_disc_unit
// Squared-distance tracker for the disc fill. One shared squarer forms
// cx^2 + cy^2 and r^2 in turn; after that the distance of the
// current scan pixel is kept up to date by adding 2*dx+1 or 2*dy+1.
// ----------------------------------------------------------------------------
module dbsf_disc_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  dbsf_pkg::dbsf_disc_ctl_type ctl,
   input  logic signed [9:0]          cx,
   input  logic signed [9:0]          cy,
   input  logic [9:0]                 r,
   output dbsf_pkg::dbsf_disc_sts_type sts
);

   logic              busy_ff, busy_in;
   logic [1:0]        mstep_ff, mstep_in;
   logic signed [9:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [9:0]        r_ff, r_in;
   logic [19:0]       prod_ff, prod_in, rr_ff, rr_in;
   logic [21:0]       base_ff, base_in, dist_ff, dist_in;
   logic signed [11:0] dx_ff, dx_in, dy_ff, dy_in;

   logic [9:0]        mul_op;
   logic signed [11:0] neg_cx, neg_cy;
   logic [21:0]       dist_col, base_row;

   always_comb begin
      case (mstep_ff)
         2'd0:    mul_op = cx_ff[9] ? 10'(-cx_ff) : 10'(cx_ff);
         2'd1:    mul_op = cy_ff[9] ? 10'(-cy_ff) : 10'(cy_ff);
         default: mul_op = r_ff;
      endcase
   end

   assign prod_in  = 20'(mul_op) * 20'(mul_op);
   assign neg_cx   = -$signed({{2{cx_ff[9]}}, cx_ff});
   assign neg_cy   = -$signed({{2{cy_ff[9]}}, cy_ff});
   // (d+1)^2 = d^2 + 2d + 1; true distance stays non-negative
   assign dist_col = dist_ff + {{9{dx_ff[11]}}, dx_ff, 1'b1};
   assign base_row = base_ff + {{9{dy_ff[11]}}, dy_ff, 1'b1};

   always_comb begin
      busy_in  = busy_ff;
      mstep_in = mstep_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      r_in     = r_ff;
      rr_in    = rr_ff;
      base_in  = base_ff;
      dist_in  = dist_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      if (ctl.start) begin
         busy_in  = 1'b1;
         mstep_in = 2'd0;
         cx_in    = cx;
         cy_in    = cy;
         r_in     = r;
      end else if (busy_ff) begin
         mstep_in = mstep_ff + 2'd1;
         case (mstep_ff)
            2'd1: base_in = {2'b00, prod_ff};
            2'd2: base_in = base_ff + {2'b00, prod_ff};
            2'd3: begin
               rr_in   = prod_ff;
               dist_in = base_ff;
               dx_in   = neg_cx;
               dy_in   = neg_cy;
               busy_in = 1'b0;
            end
            default: ;
         endcase
      end else if (ctl.row_step) begin
         base_in = base_row;
         dist_in = base_row;
         dy_in   = dy_ff + 12'sd1;
         dx_in   = neg_cx;
      end else if (ctl.col_step) begin
         dist_in = dist_col;
         dx_in   = dx_ff + 12'sd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         mstep_ff <= 2'd0;
      end else begin
         busy_ff  <= busy_in;
         mstep_ff <= mstep_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      r_ff    <= r_in;
      prod_ff <= prod_in;
      rr_ff   <= rr_in;
      base_ff <= base_in;
      dist_ff <= dist_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
   end

   assign sts.busy    = busy_ff;
   assign sts.in_disc = (dist_ff <= {2'b00, rr_ff});

endmodule

/* rtl/double_buffered_shape_fill_top.sv */
// ----------------------------------------------------------------------------
// double_buffered_shape_fill_top
// Two-page pixel store: draw commands change the back page, reads come from
// the front page, and a swap exchanges the two. Every request returns exactly
// one response (the pixel for a read, zero otherwise). After reset the block
// runs a clearing pass over both pages before it takes its first request.
// Clear, disc and box scan the whole back page at one pixel per cycle through
// the single write port of the page memory; a disc first waits while the
// shared squarer forms its start distance and radius squared. A read passes
// through address, registered memory read and response; swap and unused codes
// go straight to the response. A finished response sits in an output
// register, so the next request is taken while it waits.
// ----------------------------------------------------------------------------
module double_buffered_shape_fill_top #(
   parameter int MAP_WIDTH  = dbsf_pkg::DBSF_MAP_WIDTH,
   parameter int MAP_HEIGHT = dbsf_pkg::DBSF_MAP_HEIGHT
) (
   input  logic          clock,
   input  logic          reset,
   dbsf_req_if.sink      req_chan,
   dbsf_rsp_if.source    rsp_chan
);

   localparam int PAGE  = MAP_WIDTH * MAP_HEIGHT;
   localparam int COL_W = (MAP_WIDTH  > 1) ? $clog2(MAP_WIDTH)  : 1;
   localparam int ROW_W = (MAP_HEIGHT > 1) ? $clog2(MAP_HEIGHT) : 1;
   localparam int PIX_W = (PAGE > 1) ? $clog2(PAGE) : 1;

   // control state
   dbsf_pkg::dbsf_state_type state_ff, state_in;
   logic             back_ff, back_in;     // page that drawing goes to
   logic             page_ff, page_in;     // page under the reset clearing pass
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [PIX_W-1:0] pix_ff, pix_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // request payload and read path
   logic [2:0]        op_ff, op_in;
   logic signed [9:0] xa_ff, xa_in, ya_ff, ya_in, xb_ff, xb_in, yb_ff, yb_in;
   logic [7:0]        color_val_ff, color_val_in;
   logic [PIX_W-1:0]  rd_addr_ff, rd_addr_in;
   logic              rd_ok_ff, rd_ok_in;
   logic [7:0]        rd_data_ff;
   logic [7:0]        rsp_pixel_ff, rsp_pixel_in;

   logic [7:0] page_mem [2][PAGE];

   logic req_fire;
   logic last_col, last_row, scanning;
   logic mem_we, wr_page;
   logic [7:0] mem_wdata;
   logic in_box;
   logic signed [10:0] col_s, row_s;
   logic rsp_free;

   dbsf_pkg::dbsf_disc_ctl_type disc_ctl;
   dbsf_pkg::dbsf_disc_sts_type disc_sts;

   assign req_chan.ready = (state_ff == dbsf_pkg::ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   assign last_col = (col_ff == COL_W'(MAP_WIDTH - 1));
   assign last_row = (row_ff == ROW_W'(MAP_HEIGHT - 1));
   assign scanning = (state_ff == dbsf_pkg::ST_SCAN);

   // disc unit follows the scan position
   assign disc_ctl.start    = req_fire && (req_chan.cmd == dbsf_pkg::CMD_DISC);
   assign disc_ctl.col_step = scanning && !last_col;
   assign disc_ctl.row_step = scanning && last_col && !last_row;

   dbsf_disc_unit u_disc (
      .clock (clock),
      .reset (reset),
      .ctl   (disc_ctl),
      .cx    (req_chan.x_a),
      .cy    (req_chan.y_a),
      .r     (req_chan.radius),
      .sts   (disc_sts)
   );

   // half-open box test, all in 11-bit signed
   assign col_s  = $signed({2'b00, 9'(col_ff)});
   assign row_s  = $signed({2'b00, 9'(row_ff)});
   assign in_box = (col_s >= $signed({xa_ff[9], xa_ff})) &&
                   (col_s <  $signed({xb_ff[9], xb_ff})) &&
                   (row_s >= $signed({ya_ff[9], ya_ff})) &&
                   (row_s <  $signed({yb_ff[9], yb_ff}));

   // write side of the page memory
   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = color_val_ff;
      wr_page   = back_ff;
      if (state_ff == dbsf_pkg::ST_INIT) begin
         mem_we    = !reset;
         mem_wdata = 8'd0;
         wr_page   = page_ff;
      end else if (scanning) begin
         case (op_ff)
            dbsf_pkg::CMD_CLEAR: begin
               mem_we    = 1'b1;
               mem_wdata = 8'd0;
            end
            dbsf_pkg::CMD_DISC: mem_we = disc_sts.in_disc;
            dbsf_pkg::CMD_BOX:  mem_we = in_box;
            default:            mem_we = 1'b0;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      back_in      = back_ff;
      page_in      = page_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      pix_in       = pix_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_pixel_in = rsp_pixel_ff;
      op_in        = op_ff;
      xa_in        = xa_ff;
      ya_in        = ya_ff;
      xb_in        = xb_ff;
      yb_in        = yb_ff;
      color_val_in = color_val_ff;
      rd_addr_in   = rd_addr_ff;
      rd_ok_in     = rd_ok_ff;

      // scan position advance, used by the clearing pass and the draw scan
      if (state_ff == dbsf_pkg::ST_INIT || scanning) begin
         if (last_col) begin
            col_in = '0;
            if (last_row) begin
               row_in = '0;
               pix_in = '0;
            end else begin
               row_in = row_ff + ROW_W'(1);
               pix_in = pix_ff + PIX_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
            pix_in = pix_ff + PIX_W'(1);
         end
      end

      case (state_ff)
         dbsf_pkg::ST_INIT: begin
            if (last_col && last_row) begin
               if (page_ff) begin
                  state_in = dbsf_pkg::ST_IDLE;
               end else begin
                  page_in = 1'b1;
               end
            end
         end
         dbsf_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in        = req_chan.cmd;
               xa_in        = req_chan.x_a;
               ya_in        = req_chan.y_a;
               xb_in        = req_chan.x_b;
               yb_in        = req_chan.y_b;
               color_val_in = req_chan.color + 8'd1;
               case (req_chan.cmd)
                  dbsf_pkg::CMD_CLEAR: state_in = dbsf_pkg::ST_SCAN;
                  dbsf_pkg::CMD_DISC:  state_in = dbsf_pkg::ST_SETUP;
                  dbsf_pkg::CMD_BOX:   state_in = dbsf_pkg::ST_SCAN;
                  dbsf_pkg::CMD_SWAP: begin
                     back_in  = !back_ff;
                     state_in = dbsf_pkg::ST_DONE;
                  end
                  dbsf_pkg::CMD_READ:  state_in = dbsf_pkg::ST_RADDR;
                  default:             state_in = dbsf_pkg::ST_DONE;
               endcase
            end
         end
         dbsf_pkg::ST_SETUP: begin
            if (!disc_sts.busy) begin
               state_in = dbsf_pkg::ST_SCAN;
            end
         end
         dbsf_pkg::ST_SCAN: begin
            if (last_col && last_row) begin
               state_in = dbsf_pkg::ST_DONE;
            end
         end
         dbsf_pkg::ST_RADDR: begin
            rd_ok_in = !xa_ff[9] && !ya_ff[9] &&
                       ({2'b00, xa_ff[8:0]} < 11'(MAP_WIDTH)) &&
                       ({2'b00, ya_ff[8:0]} < 11'(MAP_HEIGHT));
            rd_addr_in = rd_ok_in ?
                         PIX_W'(ya_ff[ROW_W-1:0]) * PIX_W'(MAP_WIDTH) +
                         PIX_W'(xa_ff[COL_W-1:0]) : '0;
            state_in = dbsf_pkg::ST_RMEM;
         end
         dbsf_pkg::ST_RMEM: state_in = dbsf_pkg::ST_DONE;
         dbsf_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = (op_ff == dbsf_pkg::CMD_READ && rd_ok_ff) ?
                              rd_data_ff : 8'd0;
               state_in     = dbsf_pkg::ST_IDLE;
            end
         end
         default: state_in = dbsf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dbsf_pkg::ST_INIT;
         back_ff      <= 1'b0;
         page_ff      <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         pix_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         back_ff      <= back_in;
         page_ff      <= page_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pix_ff       <= pix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      xa_ff        <= xa_in;
      ya_ff        <= ya_in;
      xb_ff        <= xb_in;
      yb_ff        <= yb_in;
      color_val_ff <= color_val_in;
      rd_addr_ff   <= rd_addr_in;
      rd_ok_ff     <= rd_ok_in;
      rsp_pixel_ff <= rsp_pixel_in;
   end

   // page memory: one write port, one registered read port on the front page
   always_ff @(posedge clock) begin
      if (mem_we) begin
         page_mem[wr_page][pix_ff] <= mem_wdata;
      end
      rd_data_ff <= page_mem[!back_ff][rd_addr_ff];
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_value = rsp_pixel_ff;

   // linear pixel counter tracks row/column
   a_pix_track: assert property (@(posedge clock) disable iff (reset)
      pix_ff == PIX_W'(row_ff) * PIX_W'(MAP_WIDTH) + PIX_W'(col_ff))
      else $error("pixel counter out of step with row/column");

   // pages exchange only on an accepted swap
   a_swap_only: assert property (@(posedge clock) disable iff (reset)
      (back_ff != $past(back_ff)) |->
         $past(req_fire && req_chan.cmd == dbsf_pkg::CMD_SWAP))
      else $error("back page changed without a swap request");

   // disc scan never runs on a half-built start distance
   a_disc_ready: assert property (@(posedge clock) disable iff (reset)
      (scanning && op_ff == dbsf_pkg::CMD_DISC) |-> !disc_sts.busy)
      else $error("disc scan while squarer busy");

   // a new response is only launched from the done state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == dbsf_pkg::ST_DONE))
      else $error("response raised outside done state");

   // no memory writes outside the clearing pass and draw scans
   a_we_gate: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (scanning || state_ff == dbsf_pkg::ST_INIT))
      else $error("page write outside a scan");

endmodule
